// ===== rtl/core/mm64_pkg.sv =====
// Shared types and constants for the streaming MurmurHash64A engine.
// No dependencies; compile first.
`default_nettype none

package mm64_pkg;

    localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
    localparam int unsigned MIX_SHIFT = 47;
    localparam logic [3:0]  TAIL_MASK = 4'd7;
    localparam logic [3:0]  FULL_COUNT = 4'd8;

    // Partial-product phases of the shared 32x32 multiplier
    localparam logic [1:0] PH_LO    = 2'd0;   // a_lo * m_lo, full 64 bits
    localparam logic [1:0] PH_HI    = 2'd1;   // a_hi * m_lo, low half into the top word
    localparam logic [1:0] PH_CROSS = 2'd2;   // a_lo * m_hi, low half into the top word

    // Configuration register indexes
    localparam logic REG_SEED = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_LOAD,
        S_MUL,
        S_WB
    } t_state;

    // Which multiplication by MIX_MUL is in flight
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LEN,
        OP_K1,
        OP_K2,
        OP_H,
        OP_FIN
    } t_op;

    typedef struct packed {
        logic       capture;
        logic       load;
        logic       mul;
        logic       wb;
        t_op        op;
        logic [1:0] phase;
    } t_dp_cmd;

    typedef struct packed {
        logic first;
        logic last;
        logic full;
        logic tail_nz;
        logic out_full;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/core/mm64_in_if.sv =====
// Input channel of the MurmurHash64A engine: valid/ready plus one message word.
// No dependencies.
`default_nettype none

interface mm64_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        first;
    logic        last;
    logic [31:0] total_length;

    modport source (output valid, output data_word, output byte_count, output first,
                    output last, output total_length, input ready);
    modport sink   (input valid, input data_word, input byte_count, input first,
                    input last, input total_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mm64_out_if.sv =====
// Output channel of the MurmurHash64A engine: valid/ready plus the digest.
// No dependencies.
`default_nettype none

interface mm64_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest;

    modport source (output valid, output digest, input ready);
    modport sink   (input valid, input digest, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mm64_dp.sv =====
// Datapath of the MurmurHash64A engine: item registers, accumulator,
// shared 32x32 multiplier and digest output register. Uses mm64_pkg.
`default_nettype none

module mm64_dp (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire mm64_pkg::t_dp_cmd      i_cmd,
    input  wire logic [63:0]            i_seed,
    input  wire logic [63:0]            i_data_word,
    input  wire logic [3:0]             i_byte_count,
    input  wire logic                   i_first,
    input  wire logic                   i_last,
    input  wire logic [31:0]            i_total_length,
    input  wire logic                   i_out_ready,
    output mm64_pkg::t_dp_status        o_status,
    output logic                        o_out_valid,
    output logic [63:0]                 o_digest
);

    logic [63:0] r_word;
    logic [31:0] r_len;
    logic [2:0]  r_tail;
    logic        r_full;
    logic        r_first;
    logic        r_last;
    logic [63:0] r_acc;
    logic [63:0] r_ma;
    logic [63:0] r_prod;
    logic [63:0] r_digest;
    logic        r_out_valid;
    logic        n_out_valid;

    logic [3:0]  count_n;
    logic [63:0] tail_word;
    logic [63:0] operand;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;

    // Short or oversized counts become a full word except for a tail on the last item
    assign count_n = (!i_last || (i_byte_count > mm64_pkg::FULL_COUNT))
                     ? mm64_pkg::FULL_COUNT : i_byte_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_word  <= i_data_word;
            r_len   <= i_total_length;
            r_tail  <= 3'(count_n & mm64_pkg::TAIL_MASK);
            r_full  <= count_n[3];
            r_first <= i_first;
            r_last  <= i_last;
        end
    end

    // Keep only the valid tail bytes
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            tail_word[8*b +: 8] = (3'(b) < r_tail) ? r_word[8*b +: 8] : 8'h00;
        end
    end

    always_comb begin
        unique case (i_cmd.op)
            mm64_pkg::OP_LEN: operand = {32'h0, r_len};
            mm64_pkg::OP_K1:  operand = r_word;
            mm64_pkg::OP_K2:  operand = r_prod ^ (r_prod >> mm64_pkg::MIX_SHIFT);
            mm64_pkg::OP_H:   operand = r_full ? (r_acc ^ r_prod) : (r_acc ^ tail_word);
            mm64_pkg::OP_FIN: operand = r_acc ^ (r_acc >> mm64_pkg::MIX_SHIFT);
            default:          operand = r_ma;
        endcase
    end

    // Low 64 bits of operand * MIX_MUL, one partial product per cycle
    assign mul_x = (i_cmd.phase == mm64_pkg::PH_HI) ? r_ma[63:32] : r_ma[31:0];
    assign mul_y = (i_cmd.phase == mm64_pkg::PH_CROSS) ? mm64_pkg::MIX_MUL[63:32]
                                                       : mm64_pkg::MIX_MUL[31:0];
    assign mul_p = 64'(mul_x) * 64'(mul_y);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ma <= operand;
        end
        if (i_cmd.mul) begin
            if (i_cmd.phase == mm64_pkg::PH_LO) begin
                r_prod <= mul_p;
            end else begin
                r_prod <= r_prod + {mul_p[31:0], 32'h0};
            end
        end
        if (i_cmd.wb && (i_cmd.op == mm64_pkg::OP_FIN)) begin
            r_digest <= r_prod ^ (r_prod >> mm64_pkg::MIX_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 64'h0;
        end else if (i_cmd.wb) begin
            if (i_cmd.op == mm64_pkg::OP_LEN) begin
                r_acc <= i_seed ^ r_prod;
            end else if (i_cmd.op == mm64_pkg::OP_H) begin
                r_acc <= r_prod;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.wb && (i_cmd.op == mm64_pkg::OP_FIN)) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_status.first    = r_first;
    assign o_status.last     = r_last;
    assign o_status.full     = r_full;
    assign o_status.tail_nz  = (r_tail != 3'd0);
    assign o_status.out_full = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_digest          = r_digest;

endmodule

`default_nettype wire

// ===== rtl/core/mm64_ctrl.sv =====
// Sequencer of the MurmurHash64A engine: orders the multiplications of one
// item and drives the datapath commands. Uses mm64_pkg.
`default_nettype none

module mm64_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire mm64_pkg::t_dp_status   i_status,
    output logic                        o_in_ready,
    output mm64_pkg::t_dp_cmd           o_cmd
);

    mm64_pkg::t_state r_state;
    mm64_pkg::t_state n_state;
    mm64_pkg::t_op    r_op;
    mm64_pkg::t_op    n_op;
    logic [1:0]       r_phase;
    logic [1:0]       n_phase;

    // Multiplication that follows op for the item described by st
    function automatic mm64_pkg::t_op next_op(input mm64_pkg::t_op op,
                                              input mm64_pkg::t_dp_status st);
        mm64_pkg::t_op nx;
        nx = mm64_pkg::OP_NONE;
        unique case (op)
            mm64_pkg::OP_NONE: begin
                // Without first, skip the length multiply and go on from the accumulator
                if (st.first) begin
                    nx = mm64_pkg::OP_LEN;
                end else if (st.full) begin
                    nx = mm64_pkg::OP_K1;
                end else if (st.tail_nz) begin
                    nx = mm64_pkg::OP_H;
                end else if (st.last) begin
                    nx = mm64_pkg::OP_FIN;
                end
            end
            mm64_pkg::OP_LEN: begin
                if (st.full) begin
                    nx = mm64_pkg::OP_K1;
                end else if (st.tail_nz) begin
                    nx = mm64_pkg::OP_H;
                end else if (st.last) begin
                    nx = mm64_pkg::OP_FIN;
                end
            end
            mm64_pkg::OP_K1: nx = mm64_pkg::OP_K2;
            mm64_pkg::OP_K2: nx = mm64_pkg::OP_H;
            mm64_pkg::OP_H: begin
                if (st.last) begin
                    nx = mm64_pkg::OP_FIN;
                end
            end
            mm64_pkg::OP_FIN: nx = mm64_pkg::OP_NONE;
            default:          nx = mm64_pkg::OP_NONE;
        endcase
        return nx;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mm64_pkg::S_IDLE;
            r_op    <= mm64_pkg::OP_NONE;
            r_phase <= mm64_pkg::PH_LO;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_phase       = r_phase;
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.mul     = 1'b0;
        o_cmd.wb      = 1'b0;
        o_cmd.op      = r_op;
        o_cmd.phase   = r_phase;
        unique case (r_state)
            mm64_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = mm64_pkg::S_PICK;
                end
            end
            mm64_pkg::S_PICK: begin
                n_op = next_op(mm64_pkg::OP_NONE, i_status);
                if (n_op == mm64_pkg::OP_NONE) begin
                    n_state = mm64_pkg::S_IDLE;
                end else begin
                    n_state = mm64_pkg::S_LOAD;
                end
            end
            mm64_pkg::S_LOAD: begin
                o_cmd.load = 1'b1;
                n_phase    = mm64_pkg::PH_LO;
                n_state    = mm64_pkg::S_MUL;
            end
            mm64_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                if (r_phase == mm64_pkg::PH_CROSS) begin
                    n_state = mm64_pkg::S_WB;
                end else begin
                    n_phase = r_phase + 2'd1;
                end
            end
            mm64_pkg::S_WB: begin
                // hold the digest until the output register is free
                if (!((r_op == mm64_pkg::OP_FIN) && i_status.out_full)) begin
                    o_cmd.wb = 1'b1;
                    n_op     = next_op(r_op, i_status);
                    if (n_op == mm64_pkg::OP_NONE) begin
                        n_state = mm64_pkg::S_IDLE;
                    end else begin
                        n_state = mm64_pkg::S_LOAD;
                    end
                end
            end
            default: begin
                n_state = mm64_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/murmur64a_stream_hash.sv =====
// Top level of the streaming MurmurHash64A engine with its APB seed register.
// Depends on mm64_pkg, mm64_in_if, mm64_out_if, mm64_ctrl and mm64_dp.
`default_nettype none

// MurmurHash64A over a message streamed as little-endian 64-bit words on i_in;
// the item marked first also carries the total byte length, the item marked last
// may hold 0 to 7 tail bytes, and one digest transfer per message leaves on o_out.
// Items are taken one at a time. Every multiplication by the mixing constant
// runs on one shared 32x32 multiplier as an operand load, three partial
// products and a write-back. After capture and a pick step, an item runs its
// multiplications in turn: three for a full word, one for a tail, plus one when
// the item starts a message and one for finalisation on the last item. The
// digest sits in an output register, so the next item is taken while it
// waits; only a second digest stalls behind one not yet taken. The seed lives
// at APB address 0 (64-bit data); the user must write it only while the engine
// is idle, which the block itself does not enforce. The accumulator is not
// cleared by the last item: a message that does not start with first set
// carries on from whatever state was left.

module murmur64a_stream_hash (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    mm64_in_if.sink           i_in,
    mm64_out_if.source        o_out
);

    logic [63:0]           r_seed;
    logic                  reg_index;
    mm64_pkg::t_dp_cmd     cmd;
    mm64_pkg::t_dp_status  status;

    // Register index is the 8-byte slot number
    assign reg_index = paddr[3];
    assign pready    = 1'b1;

    // Write the seed on the APB access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 64'h0;
        end else if (psel && penable && pwrite && pready
                     && (reg_index == mm64_pkg::REG_SEED)) begin
            r_seed <= pwdata;
        end
    end

    assign prdata = (reg_index == mm64_pkg::REG_SEED) ? r_seed : 64'h0;

    // Sequencer: decides which multiplication runs next
    mm64_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    // Datapath: holds the item, the accumulator and the digest register
    mm64_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_seed         (r_seed),
        .i_data_word    (i_in.data_word),
        .i_byte_count   (i_in.byte_count),
        .i_first        (i_in.first),
        .i_last         (i_in.last),
        .i_total_length (i_in.total_length),
        .i_out_ready    (o_out.ready),
        .o_status       (status),
        .o_out_valid    (o_out.valid),
        .o_digest       (o_out.digest)
    );

endmodule

`default_nettype wire

// ===== tb/sv/murmur64a_stream_hash_tb.sv =====
// Self-checking testbench for murmur64a_stream_hash: streams messages of 64-bit
// words, predicts every digest with a behavioural MurmurHash64A and checks each transfer.
// Depends on mm64_pkg, mm64_in_if, mm64_out_if and the engine RTL.
module murmur64a_stream_hash_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Mixing constants of MurmurHash64A, kept here so the prediction stands apart
    // from the design's package.
    localparam logic [63:0] HASH_M = 64'hc6a4a7935bd1e995;
    localparam int unsigned HASH_R = 47;

    // Seed register sits at byte address 8 * index (64-bit data)
    localparam logic [3:0] SEED_ADDR = {mm64_pkg::REG_SEED, 3'b000};

    // Worst item: length multiply, three word multiplies and finalisation. Give
    // a clear margin before touching the seed.
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned DRAIN_LIMIT   = 20000;
    localparam int unsigned RANDOM_ITEMS  = 1650;
    localparam int unsigned QUIET_TAIL    = 200;
    localparam int unsigned SEED_EVERY    = 400;
    localparam int unsigned PAUSE_EVERY   = 150;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned MAX_REPORTS   = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    mm64_in_if  in_ch ();
    mm64_out_if out_ch ();

    murmur64a_stream_hash u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Behavioural copy of the engine state and its seed register
    logic [63:0] model_seed  = '0;
    logic [63:0] model_accum = '0;

    // Digests still owed by the engine, oldest first
    logic [63:0] pending_digests[$];

    int unsigned mismatches        = 0;
    int unsigned items_sent        = 0;
    bit          src_idle_en       = 1'b1;
    bit          sink_stall_en     = 1'b1;
    int unsigned sink_hold_cycles  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Guard against a hung engine; far beyond the slowest legal run.
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Absorb one input item into the model accumulator. Returns 1 when the item
    // closes a message, with the finalised hash in digest.
    function automatic bit absorb_item(input logic [63:0] word, input logic [3:0] count,
                                       input logic is_first, input logic is_last,
                                       input logic [31:0] length, output logic [63:0] digest);
        logic [63:0] h;
        logic [63:0] k;
        logic [63:0] tail_mask;
        int unsigned nbytes;
        // Only the last item may carry a short word; anything else, and any
        // count above eight, is taken as a full word.
        nbytes = count;
        if (!is_last || count > 4'd8)
            nbytes = 8;
        h = is_first ? (model_seed ^ (64'(length) * HASH_M)) : model_accum;
        if (nbytes == 8) begin
            k = word * HASH_M;
            k = k ^ (k >> HASH_R);
            k = k * HASH_M;
            h = (h ^ k) * HASH_M;
        end else if (nbytes != 0) begin
            // Bytes above the tail are don't-care
            tail_mask = (64'd1 << (nbytes * 8)) - 64'd1;
            h = (h ^ (word & tail_mask)) * HASH_M;
        end
        // The accumulator keeps the unfinalised value, even after a last item
        model_accum = h;
        h = h ^ (h >> HASH_R);
        h = h * HASH_M;
        h = h ^ (h >> HASH_R);
        digest = h;
        return is_last;
    endfunction

    // ------------------------------------------------------------------
    // Digest side: receiver and checker
    // ------------------------------------------------------------------

    // Receiver: ready with random stall bursts, or one long hold-off when a test
    // asks for it. Each branch drives ready once and then waits at least one edge.
    initial begin : digest_sink
        forever begin
            if (sink_hold_cycles != 0) begin
                out_ch.ready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge i_clk);
                sink_hold_cycles = 0;
            end else if (sink_stall_en && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Checker: compare every digest transfer with the oldest prediction.
    always @(posedge i_clk) begin : digest_check
        logic [63:0] want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_digests.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: digest %h arrived with none pending", $realtime,
                             out_ch.digest);
            end else begin
                want = pending_digests.pop_front();
                if (out_ch.digest !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: digest mismatch: expected %h, got %h", $realtime,
                                 want, out_ch.digest);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one item, optionally after a short idle burst, and hold it until the
    // engine takes it. Returns on the edge of the transfer with valid still high.
    task automatic send_item(input logic [63:0] word, input logic [3:0] count,
                             input logic is_first, input logic is_last,
                             input logic [31:0] length);
        logic [63:0] digest;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.data_word    <= word;
        in_ch.byte_count   <= count;
        in_ch.first        <= is_first;
        in_ch.last         <= is_last;
        in_ch.total_length <= length;
        do @(posedge i_clk); while (!in_ch.ready);
        if (absorb_item(word, count, is_first, is_last, length, digest))
            pending_digests.push_back(digest);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted digest has been taken.
    // Always advances at least one edge, so the next drive lands on a fresh step.
    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_digests.size() != 0);
    endtask

    // One APB transfer: setup, access, then one spare edge so back-to-back
    // calls never drive psel twice on the same step.
    task automatic apb_access(input logic write, input logic [3:0] addr,
                              input logic [63:0] wdata, output logic [63:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Change the seed with the engine idle, then read it back.
    task automatic set_seed(input logic [63:0] value);
        logic [63:0] readback;
        hold_until_drained();
        // An item that closes no message may still be in the datapath
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        apb_access(1'b1, SEED_ADDR, value, readback);
        model_seed = value;
        apb_access(1'b0, SEED_ADDR, '0, readback);
        if (readback !== value) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: seed readback: expected %h, got %h", $realtime,
                         value, readback);
        end
    endtask

    // Random message. Mostly well formed with random content; a few are a single
    // noise item, a length that disagrees, a missing first flag, or odd counts
    // on full words.
    task automatic send_random_message();
        int unsigned kind;
        int unsigned len;
        int unsigned nwords;
        int unsigned tail;
        int unsigned n_items;
        bit          empty_close;
        bit          is_last;
        logic [3:0]  cnt;
        logic [31:0] len_field;
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
            send_item({$urandom, $urandom}, 4'($urandom), 1'($urandom), 1'($urandom),
                      $urandom);
            return;
        end
        // Keep most messages short; now and then a long one
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 240) : $urandom_range(0, 40);
        nwords = len / 8;
        tail   = len % 8;
        len_field = (kind == 2) ? $urandom : len;
        // A word-aligned message may close on its last word or on an empty item
        empty_close = (tail == 0) && (len != 0) && $urandom_range(0, 3) == 0;
        if (len == 0)
            n_items = 1;
        else
            n_items = nwords + ((tail != 0 || empty_close) ? 1 : 0);
        for (int unsigned i = 0; i < n_items; i++) begin
            is_last = (i == n_items - 1);
            if (i < nwords) begin
                if (kind == 4)
                    cnt = is_last ? 4'($urandom_range(8, 15)) : 4'($urandom);
                else
                    cnt = 4'd8;
            end else begin
                cnt = empty_close ? 4'd0 : 4'(tail);
            end
            send_item({$urandom, $urandom}, cnt, (i == 0) && (kind != 3), is_last,
                      (i == 0) ? len_field : $urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes and the corner cases, with the seed still at its reset value.
    task automatic test_directed();
        // Missing first straight after reset: carry on from a zero accumulator
        send_item(64'h0123_4567_89ab_cdef, 4'd8, 1'b0, 1'b1, 32'd0);
        // Empty message
        send_item(64'h0, 4'd0, 1'b1, 1'b1, 32'd0);
        // Every tail size, with all unused bytes set
        for (int unsigned n = 1; n < 8; n++)
            send_item('1, 4'(n), 1'b1, 1'b1, 32'(n));
        // Full single words at the extremes of data and length
        send_item('1, 4'd8, 1'b1, 1'b1, 32'hffff_ffff);
        send_item(64'h0, 4'd8, 1'b1, 1'b1, 32'd8);
        // Three items: a short count on a middle word is taken as a full word
        send_item(64'h8000_0000_0000_0001, 4'd8, 1'b1, 1'b0, 32'd21);
        send_item(64'h5a5a_5a5a_a5a5_a5a5, 4'd3, 1'b0, 1'b0, 32'hdead_beef);
        send_item(64'hffff_ff00_0000_00ff, 4'd5, 1'b0, 1'b1, 32'd0);
        // Oversized counts, mid-message and on the last item
        send_item(64'h1357_9bdf_0246_8ace, 4'd15, 1'b1, 1'b0, 32'd16);
        send_item(64'hfedc_ba98_7654_3210, 4'd9, 1'b0, 1'b1, 32'd16);
        // After last, continue without first from the unfinalised accumulator
        send_item(64'h0f0f_0f0f_f0f0_f0f0, 4'd8, 1'b0, 1'b1, 32'd0);
        // Empty closing item after a full word
        send_item(64'h7fff_ffff_ffff_ffff, 4'd8, 1'b1, 1'b0, 32'd8);
        send_item(64'hffff_ffff_ffff_ffff, 4'd0, 1'b0, 1'b1, 32'd8);
        // Length that disagrees with the data
        send_item(64'h0000_0000_0000_abcd, 4'd2, 1'b1, 1'b1, 32'd1000);
        // A first flag in mid-message restarts the accumulator
        send_item(64'h2468_ace0_1357_9bdf, 4'd8, 1'b1, 1'b0, 32'd16);
        send_item(64'h9bdf_1357_ace0_2468, 4'd8, 1'b1, 1'b1, 32'd16);
    endtask

    // Seed extremes, each followed by a small mix of messages.
    task automatic test_seed_extremes();
        logic [63:0] seeds[4];
        seeds[0] = '1;
        seeds[1] = 64'h8000_0000_0000_0000;
        seeds[2] = 64'h1;
        seeds[3] = {$urandom, $urandom};
        foreach (seeds[s]) begin
            set_seed(seeds[s]);
            send_item(64'h0, 4'd0, 1'b1, 1'b1, 32'd0);
            send_item({$urandom, $urandom}, 4'($urandom_range(1, 7)), 1'b1, 1'b1,
                      $urandom);
            send_item({$urandom, $urandom}, 4'd8, 1'b1, 1'b0, 32'd12);
            send_item({$urandom, $urandom}, 4'd4, 1'b0, 1'b1, 32'd12);
        end
        set_seed('0);
    endtask

    // Hold the receiver off for a long stretch while single-item messages keep
    // coming, so the output register fills and the input stalls.
    task automatic test_output_backpressure();
        src_idle_en = 1'b0;
        sink_hold_cycles = LONG_HOLD;
        for (int unsigned i = 0; i < 12; i++)
            send_item({$urandom, $urandom}, 4'($urandom_range(0, 8)), 1'b1, 1'b1, $urandom);
        hold_until_drained();
        src_idle_en = 1'b1;
    endtask

    // Random stream with occasional seed changes and full drains; no idling at all
    // in the closing stretch.
    task automatic test_random_stream();
        int unsigned start;
        int unsigned next_seed_at;
        int unsigned next_pause_at;
        logic [63:0] seed_val;
        bit          quiet;
        start         = items_sent;
        next_seed_at  = start + SEED_EVERY;
        next_pause_at = start + PAUSE_EVERY;
        while (items_sent - start < RANDOM_ITEMS) begin
            quiet = (items_sent - start >= RANDOM_ITEMS - QUIET_TAIL);
            if (quiet) begin
                src_idle_en   = 1'b0;
                sink_stall_en = 1'b0;
            end
            if (!quiet && items_sent >= next_seed_at) begin
                case ($urandom_range(0, 2))
                    0:       seed_val = '0;
                    1:       seed_val = '1;
                    default: seed_val = {$urandom, $urandom};
                endcase
                set_seed(seed_val);
                next_seed_at += SEED_EVERY;
            end else if (!quiet && items_sent >= next_pause_at) begin
                hold_until_drained();
                next_pause_at += PAUSE_EVERY;
            end
            send_random_message();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin : run
        int unsigned waited;
        // Drive every input to a known value while holding reset, then release it
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.data_word    <= '0;
        in_ch.byte_count   <= '0;
        in_ch.first        <= 1'b0;
        in_ch.last         <= 1'b0;
        in_ch.total_length <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_seed_extremes();
        test_output_backpressure();
        test_random_stream();

        // Drop valid, let the last digests out, then allow the pipeline to settle
        in_ch.valid <= 1'b0;
        waited = 0;
        while (pending_digests.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_digests.size() != 0)
            $display("%0d digests never arrived", pending_digests.size());

        if (mismatches == 0 && pending_digests.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
